// ===== rtl/awcn_pkg.sv =====
// Shared types, constants and fixed-point helpers for the affine warp
// composer and normalizer. No dependencies.
`default_nettype none
package awcn_pkg;

    localparam int DEF_MAX_OBS      = 64;
    localparam int DEF_MAX_CLUSTERS = 16;
    localparam int Q_W              = 32;
    localparam int SUM_W            = 40;
    localparam int CNT_W            = 7;
    localparam int DIV_N            = 50;
    localparam int MUL_N            = 32;
    localparam int ADDR_W           = 3;

    localparam logic [Q_W-1:0] Q_ONE = 32'h0001_0000;

    // register select is byte address bit 2
    localparam logic REG_OBS_COUNT  = 1'b0;
    localparam logic REG_CLUSTER_EN = 1'b1;

    typedef enum logic [1:0] {
        REQ_COMPOSE = 2'd0,
        REQ_MEMBER  = 2'd1,
        REQ_FINISH  = 2'd2,
        REQ_RESTART = 2'd3
    } t_req;

    typedef struct packed {
        t_req               req_type;
        logic [5:0]         obs_index;
        logic signed [31:0] step_dilation;
        logic signed [31:0] step_shift;
        logic [3:0]         cluster_id;
    } t_in_item;

    typedef struct packed {
        logic [5:0]         out_index;
        logic signed [31:0] norm_dilation;
        logic signed [31:0] norm_shift;
        logic [3:0]         out_cluster;
        logic               zero_mean;
        logic               last;
    } t_out_item;

    function automatic logic signed [31:0] sat32(input logic signed [49:0] v);
        logic signed [49:0] hi;
        logic signed [49:0] lo;
        hi = {18'd0, 32'h7FFF_FFFF};
        lo = {{18{1'b1}}, 32'h8000_0000};
        if (v > hi) begin
            return 32'sh7FFF_FFFF;
        end else if (v < lo) begin
            return 32'sh8000_0000;
        end
        return v[31:0];
    endfunction

    // saturate a sign and magnitude quotient to Q16.16
    function automatic logic signed [31:0] qsat(input logic neg, input logic [49:0] mag);
        logic [31:0] m;
        m = mag[31:0];
        if (!neg) begin
            if (mag > 50'h0_7FFF_FFFF) begin
                return 32'sh7FFF_FFFF;
            end
            return m;
        end
        if (mag > 50'h0_8000_0000) begin
            return 32'sh8000_0000;
        end
        return ~m + 32'd1;
    endfunction

endpackage
`default_nettype wire

// ===== rtl/awcn_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module awcn_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

// ===== rtl/affine_warp_compose_normalize.sv =====
// Affine warp composer and per-cluster normalizer, top level.
// Depends on awcn_pkg and awcn_ram.
//
// Usage: items enter on i_in (valid/stall), results leave on o_out
// (valid/stall), registers are written through the APB port
// (obs_count at 0x0, cluster_enable at 0x4).
// A compose item folds a warp step into one observation with a bit-serial
// multiplier; the input stalls until the read, multiply, rounding and write
// states are done. Membership and restart items do not stall the input. A
// finish item first walks the observations to build cluster sums, then
// emits one result per observation in index order. A normalized observation
// goes through up to four passes of the shared restoring divider, one
// quotient bit a cycle (mean dilation, mean shift, two quotients of 50 bits
// each); a zero mean dilation ends the divisions after the first pass.
// The result sits in an output register; a stall by the receiver holds the
// walk until it is taken. New items are taken once the walk is done, even
// while the final result still waits.
// After reset every warp is the identity, every membership zero, obs_count
// 64 and all clusters enabled; there is no clearing pass.
`default_nettype none
module affine_warp_compose_normalize #(
    parameter int MAX_OBS      = awcn_pkg::DEF_MAX_OBS,
    parameter int MAX_CLUSTERS = awcn_pkg::DEF_MAX_CLUSTERS
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_in_valid,
    output logic                            o_in_stall,
    input  wire awcn_pkg::t_in_item         i_in,
    output logic                            o_out_valid,
    input  wire logic                       i_out_stall,
    output awcn_pkg::t_out_item             o_out,
    input  wire logic                       psel,
    input  wire logic                       penable,
    input  wire logic                       pwrite,
    input  wire logic [awcn_pkg::ADDR_W-1:0] paddr,
    input  wire logic [31:0]                pwdata,
    output logic      [31:0]                prdata,
    output logic                            pready
);
    import awcn_pkg::*;

    localparam int OBS_W = $clog2(MAX_OBS);
    localparam int CL_W  = (MAX_CLUSTERS > 1) ? $clog2(MAX_CLUSTERS) : 1;
    localparam logic [CNT_W-1:0] MAX_N  = CNT_W'(MAX_OBS);
    localparam logic [4:0]       NCLUST = 5'(MAX_CLUSTERS);

    typedef enum logic [3:0] {
        S_IDLE, S_C_RD, S_C_MUL, S_C_RND, S_C_WR,
        S_A_ISS, S_A_ACC, S_E_ISS, S_E_LD, S_E_DIV, S_E_OUT
    } t_state;

    typedef enum logic [1:0] {OP_MD, OP_MS, OP_ND, OP_NS} t_dop;

    t_state r_state;
    t_dop   r_op;

    logic [CNT_W-1:0] r_obs_count;
    logic [15:0]      r_cl_en;
    logic [OBS_W-1:0] r_idx;
    logic [5:0]       r_cnt;
    logic [MAX_OBS-1:0] r_wvld;
    logic [MAX_OBS-1:0] r_mvld;

    logic signed [SUM_W-1:0] r_sum_d [MAX_CLUSTERS];
    logic signed [SUM_W-1:0] r_sum_s [MAX_CLUSTERS];
    logic [CNT_W-1:0]        r_ccnt  [MAX_CLUSTERS];

    // compose datapath
    logic signed [31:0] r_ma_d, r_ma_s, r_ss;
    logic [31:0]        r_mb;
    logic signed [33:0] r_pd_hi, r_ps_hi;
    logic [31:0]        r_pd_lo, r_ps_lo;
    logic signed [47:0] r_pd_r, r_ps_r;

    // finish datapath
    logic signed [31:0] r_d, r_s, r_md, r_ms;
    logic [3:0]         r_c;
    logic [CL_W-1:0]    r_cidx;
    logic [DIV_N-1:0]   r_dq;
    logic [31:0]        r_rem, r_dvs;
    logic               r_dneg;
    logic signed [31:0] r_nd, r_ns;
    logic               r_zm;

    logic      r_out_vld;
    t_out_item r_out;

    // effective observation count
    logic [CNT_W-1:0] n_eff;
    always_comb begin
        if (r_obs_count == '0) begin
            n_eff = CNT_W'(1);
        end else if (r_obs_count > MAX_N) begin
            n_eff = MAX_N;
        end else begin
            n_eff = r_obs_count;
        end
    end

    logic in_acc, cfg_wr, idx_ok, idx_last, out_free;
    assign in_acc   = i_in_valid && !o_in_stall;
    assign cfg_wr   = psel && penable && pwrite && pready;
    assign idx_ok   = ({1'b0, i_in.obs_index} < n_eff);
    assign idx_last = (CNT_W'(r_idx) + CNT_W'(1) == n_eff);
    assign out_free = !r_out_vld || !i_out_stall;

    // memories
    logic [OBS_W-1:0] ram_raddr;
    logic [63:0]      warp_rd, warp_wd;
    logic [3:0]       memb_rd;
    logic             warp_we, memb_we;

    assign ram_raddr = (r_state == S_IDLE) ? i_in.obs_index[OBS_W-1:0] : r_idx;
    assign warp_we   = (r_state == S_C_WR);
    assign memb_we   = in_acc && (i_in.req_type == REQ_MEMBER) && idx_ok;

    awcn_ram #(.WIDTH(64), .DEPTH(MAX_OBS)) u_warp_ram (
        .i_clk  (i_clk),
        .i_we   (warp_we),
        .i_waddr(r_idx),
        .i_wdata(warp_wd),
        .i_raddr(ram_raddr),
        .o_rdata(warp_rd)
    );

    awcn_ram #(.WIDTH(4), .DEPTH(MAX_OBS)) u_memb_ram (
        .i_clk  (i_clk),
        .i_we   (memb_we),
        .i_waddr(i_in.obs_index[OBS_W-1:0]),
        .i_wdata(i_in.cluster_id),
        .i_raddr(ram_raddr),
        .o_rdata(memb_rd)
    );

    // entries never written read as identity warp and cluster zero
    logic signed [31:0] rd_d, rd_s;
    logic [3:0]         rd_c;
    logic               rd_in_range;
    logic [CL_W-1:0]    rd_cidx;
    assign rd_d        = r_wvld[r_idx] ? warp_rd[63:32] : Q_ONE;
    assign rd_s        = r_wvld[r_idx] ? warp_rd[31:0] : '0;
    assign rd_c        = r_mvld[r_idx] ? memb_rd : '0;
    assign rd_in_range = ({1'b0, rd_c} < NCLUST);
    assign rd_cidx     = rd_c[CL_W-1:0];

    // bit-serial signed multiply step, multiplier LSB first
    logic               mul_last;
    logic signed [33:0] mul_add_d, mul_add_s, mul_sum_d, mul_sum_s;
    logic signed [63:0] rnd_d, rnd_s;
    always_comb begin
        mul_last  = (r_cnt == 6'(MUL_N - 1));
        mul_add_d = '0;
        mul_add_s = '0;
        if (r_mb[0]) begin
            mul_add_d = mul_last ? -34'(r_ma_d) : 34'(r_ma_d);
            mul_add_s = mul_last ? -34'(r_ma_s) : 34'(r_ma_s);
        end
        mul_sum_d = r_pd_hi + mul_add_d;
        mul_sum_s = r_ps_hi + mul_add_s;
        rnd_d     = $signed({r_pd_hi[31:0], r_pd_lo}) + 64'sh8000;
        rnd_s     = $signed({r_ps_hi[31:0], r_ps_lo}) + 64'sh8000;
    end

    assign warp_wd = {sat32(50'(r_pd_r)), sat32(50'(r_ps_r) + 50'(r_ss))};

    // restoring divider step, one quotient bit a cycle
    logic [32:0]      div_rr;
    logic             div_ge, div_done;
    logic [31:0]      div_rem_n;
    logic [DIV_N-1:0] div_q_n;
    logic [31:0]      div_mean;
    always_comb begin
        div_rr    = {r_rem, r_dq[DIV_N-1]};
        div_ge    = (div_rr >= {1'b0, r_dvs});
        div_rem_n = div_ge ? 32'(div_rr - {1'b0, r_dvs}) : div_rr[31:0];
        div_q_n   = {r_dq[DIV_N-2:0], div_ge};
        div_done  = (r_cnt == 6'(DIV_N - 1));
        div_mean  = r_dneg ? -div_q_n[31:0] : div_q_n[31:0];
    end

    // operands for the next division
    logic signed [SUM_W-1:0] cur_sum_s;
    logic [SUM_W-1:0]        abs_sum_s;
    logic [31:0]             abs_md, abs_d;
    logic signed [32:0]      diff_s;
    logic [32:0]             abs_diff;
    always_comb begin
        cur_sum_s = r_sum_s[r_cidx];
        abs_sum_s = cur_sum_s[SUM_W-1] ? -cur_sum_s : cur_sum_s;
        abs_md    = r_md[31] ? -r_md : r_md;
        abs_d     = r_d[31] ? -r_d : r_d;
        diff_s    = 33'(r_s) - 33'(r_ms);
        abs_diff  = diff_s[32] ? -diff_s : diff_s;
    end

    logic signed [SUM_W-1:0] ld_sum_d;
    logic [SUM_W-1:0]        ld_abs_d;
    logic                    ld_elig;
    always_comb begin
        ld_sum_d = r_sum_d[rd_cidx];
        ld_abs_d = ld_sum_d[SUM_W-1] ? -ld_sum_d : ld_sum_d;
        ld_elig  = rd_in_range && r_cl_en[rd_c] && (r_ccnt[rd_cidx] != '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_op        <= OP_MD;
            r_obs_count <= CNT_W'(64);
            r_cl_en     <= 16'hFFFF;
            r_wvld      <= '0;
            r_mvld      <= '0;
            r_out_vld   <= 1'b0;
            r_idx       <= '0;
            r_cnt       <= '0;
        end else begin
            if (cfg_wr) begin
                unique case (paddr[2])
                    REG_OBS_COUNT:  r_obs_count <= pwdata[CNT_W-1:0];
                    REG_CLUSTER_EN: r_cl_en     <= pwdata[15:0];
                    default: ;
                endcase
            end
            if (r_out_vld && !i_out_stall) begin
                r_out_vld <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_idx <= i_in.obs_index[OBS_W-1:0];
                        r_mb  <= i_in.step_dilation;
                        r_ss  <= i_in.step_shift;
                        unique case (i_in.req_type)
                            REQ_COMPOSE: begin
                                if (idx_ok) begin
                                    r_state <= S_C_RD;
                                end
                            end
                            REQ_MEMBER: begin
                                if (idx_ok) begin
                                    r_mvld[i_in.obs_index[OBS_W-1:0]] <= 1'b1;
                                end
                            end
                            REQ_RESTART: r_wvld <= '0;
                            REQ_FINISH: begin
                                for (int k = 0; k < MAX_CLUSTERS; k++) begin
                                    r_sum_d[k] <= '0;
                                    r_sum_s[k] <= '0;
                                    r_ccnt[k]  <= '0;
                                end
                                r_idx   <= '0;
                                r_state <= S_A_ISS;
                            end
                            default: ;
                        endcase
                    end
                end
                S_C_RD: begin
                    r_ma_d  <= rd_d;
                    r_ma_s  <= rd_s;
                    r_pd_hi <= '0;
                    r_ps_hi <= '0;
                    r_cnt   <= '0;
                    r_state <= S_C_MUL;
                end
                S_C_MUL: begin
                    r_pd_hi <= mul_sum_d >>> 1;
                    r_ps_hi <= mul_sum_s >>> 1;
                    r_pd_lo <= {mul_sum_d[0], r_pd_lo[31:1]};
                    r_ps_lo <= {mul_sum_s[0], r_ps_lo[31:1]};
                    r_mb    <= r_mb >> 1;
                    r_cnt   <= r_cnt + 6'd1;
                    if (mul_last) begin
                        r_state <= S_C_RND;
                    end
                end
                S_C_RND: begin
                    r_pd_r  <= rnd_d[63:16];
                    r_ps_r  <= rnd_s[63:16];
                    r_state <= S_C_WR;
                end
                S_C_WR: begin
                    r_wvld[r_idx] <= 1'b1;
                    r_state       <= S_IDLE;
                end
                S_A_ISS: r_state <= S_A_ACC;
                S_A_ACC: begin
                    if (rd_in_range) begin
                        r_sum_d[rd_cidx] <= r_sum_d[rd_cidx] + SUM_W'(rd_d);
                        r_sum_s[rd_cidx] <= r_sum_s[rd_cidx] + SUM_W'(rd_s);
                        r_ccnt[rd_cidx]  <= r_ccnt[rd_cidx] + CNT_W'(1);
                    end
                    if (idx_last) begin
                        r_idx   <= '0;
                        r_state <= S_E_ISS;
                    end else begin
                        r_idx   <= r_idx + OBS_W'(1);
                        r_state <= S_A_ISS;
                    end
                end
                S_E_ISS: r_state <= S_E_LD;
                S_E_LD: begin
                    r_d    <= rd_d;
                    r_s    <= rd_s;
                    r_c    <= rd_c;
                    r_cidx <= rd_cidx;
                    r_nd   <= rd_d;
                    r_ns   <= rd_s;
                    r_zm   <= 1'b0;
                    if (ld_elig) begin
                        r_dq    <= DIV_N'(ld_abs_d);
                        r_dvs   <= 32'(r_ccnt[rd_cidx]);
                        r_dneg  <= ld_sum_d[SUM_W-1];
                        r_rem   <= '0;
                        r_cnt   <= '0;
                        r_op    <= OP_MD;
                        r_state <= S_E_DIV;
                    end else begin
                        r_state <= S_E_OUT;
                    end
                end
                S_E_DIV: begin
                    r_dq  <= div_q_n;
                    r_rem <= div_rem_n;
                    r_cnt <= r_cnt + 6'd1;
                    if (div_done) begin
                        r_rem <= '0;
                        r_cnt <= '0;
                        unique case (r_op)
                            OP_MD: begin
                                r_md <= div_mean;
                                if (div_mean == '0) begin
                                    r_zm    <= 1'b1;
                                    r_state <= S_E_OUT;
                                end else begin
                                    r_dq   <= DIV_N'(abs_sum_s);
                                    r_dneg <= cur_sum_s[SUM_W-1];
                                    r_op   <= OP_MS;
                                end
                            end
                            OP_MS: begin
                                r_ms   <= div_mean;
                                r_dq   <= {2'b00, abs_d, 16'h0000};
                                r_dvs  <= abs_md;
                                r_dneg <= r_d[31] ^ r_md[31];
                                r_op   <= OP_ND;
                            end
                            OP_ND: begin
                                r_nd   <= qsat(r_dneg, div_q_n);
                                r_dq   <= {1'b0, abs_diff, 16'h0000};
                                r_dneg <= diff_s[32] ^ r_md[31];
                                r_op   <= OP_NS;
                            end
                            OP_NS: begin
                                r_ns    <= qsat(r_dneg, div_q_n);
                                r_state <= S_E_OUT;
                            end
                            default: ;
                        endcase
                    end
                end
                S_E_OUT: begin
                    // hold until the output register is free
                    if (out_free) begin
                        r_out_vld           <= 1'b1;
                        r_out.out_index     <= 6'(r_idx);
                        r_out.norm_dilation <= r_nd;
                        r_out.norm_shift    <= r_ns;
                        r_out.out_cluster   <= r_c;
                        r_out.zero_mean     <= r_zm;
                        r_out.last          <= idx_last;
                        if (idx_last) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_idx   <= r_idx + OBS_W'(1);
                            r_state <= S_E_ISS;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_vld;
    assign o_out       = r_out;
    assign pready      = 1'b1;

    always_comb begin
        unique case (paddr[2])
            REG_OBS_COUNT:  prdata = {25'd0, r_obs_count};
            REG_CLUSTER_EN: prdata = {16'd0, r_cl_en};
            default:        prdata = '0;
        endcase
    end

`ifndef SYNTHESIS
    a_div_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_E_DIV) |-> (r_cnt < 6'(DIV_N)))
        else $error("divider ran past its last step");

    a_compose_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_in.req_type == REQ_COMPOSE && idx_ok) |=> (r_state == S_C_RD))
        else $error("compose item did not start its read");

    a_walk_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_E_ISS || r_state == S_A_ISS) |-> (CNT_W'(r_idx) < n_eff))
        else $error("walk index beyond observation count");

    a_last_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out.last) |-> (CNT_W'(o_out.out_index) + CNT_W'(1) == n_eff))
        else $error("last flag on wrong observation");
`endif
endmodule
`default_nettype wire

// ===== tb/affine_warp_compose_normalize_test.sv =====
// Self-checking testbench for affine_warp_compose_normalize: a directed table, then random
// phases under several register settings, checked against a local warp/normalize predictor.
// Depends on awcn_pkg and the RTL of the block.
`default_nettype none
module affine_warp_compose_normalize_test;
    timeunit 1ns;
    timeprecision 1ps;
    import awcn_pkg::*;

    localparam int N_OBS = 64;
    localparam int N_CLU = 16;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int SETTLE_CYCLES = 300;
    localparam int ITEMS_PER_PHASE = 40;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_in_valid = 1'b0;
    logic o_in_stall;
    t_in_item i_in = '0;
    logic o_out_valid;
    logic i_out_stall = 1'b0;
    t_out_item o_out;
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [ADDR_W-1:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;

    affine_warp_compose_normalize i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_stall(o_in_stall), .i_in(i_in),
        .o_out_valid(o_out_valid), .i_out_stall(i_out_stall), .o_out(o_out),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // predictor state
    logic signed [31:0] warp_dil[N_OBS];
    logic signed [31:0] warp_shf[N_OBS];
    logic [3:0] member_of[N_OBS];
    logic [6:0] cfg_obs_count;
    logic [15:0] cfg_cluster_en;
    t_out_item pending_results[$];

    int errors = 0;
    int results_seen = 0;
    int finishes_sent = 0;
    int stall_left = 0;
    int idle_cycles = 0;
    logic burst = 1'b0;

    typedef struct {
        t_in_item item;
        int new_count;          // -1: keep obs_count
        bit fixed;              // expected values typed in below
        logic [31:0] fix_dil;
        logic [31:0] fix_shf;
        bit fix_zero;
    } t_row;

    t_row directed[$];

    function automatic int active_obs();
        int n;
        n = cfg_obs_count;
        if (n < 1) n = 1;
        if (n > N_OBS) n = N_OBS;
        return n;
    endfunction

    function automatic logic signed [31:0] clamp_q(longint v);
        if (v > 64'sd2147483647) return 32'sh7FFF_FFFF;
        if (v < -64'sd2147483648) return 32'sh8000_0000;
        return v[31:0];
    endfunction

    function automatic longint round_mul(longint a, longint b);
        return (a * b + 64'sd32768) >>> 16;
    endfunction

    task automatic compose_or_finish(t_in_item it);
        longint sum_d[N_CLU];
        longint sum_s[N_CLU];
        int cnt[N_CLU];
        int n;
        int c;
        longint md;
        longint ms;
        t_out_item r;
        n = active_obs();
        case (it.req_type)
            REQ_COMPOSE: begin
                if (it.obs_index < n) begin
                    warp_shf[it.obs_index] = clamp_q(round_mul(
                        longint'(warp_shf[it.obs_index]), longint'($signed(it.step_dilation)))
                        + longint'($signed(it.step_shift)));
                    warp_dil[it.obs_index] = clamp_q(round_mul(
                        longint'(warp_dil[it.obs_index]), longint'($signed(it.step_dilation))));
                end
            end
            REQ_MEMBER: begin
                if (it.obs_index < n) member_of[it.obs_index] = it.cluster_id;
            end
            REQ_RESTART: begin
                for (int i = 0; i < N_OBS; i++) begin
                    warp_dil[i] = Q_ONE;
                    warp_shf[i] = '0;
                end
            end
            default: begin
                for (int k = 0; k < N_CLU; k++) begin
                    sum_d[k] = 0;
                    sum_s[k] = 0;
                    cnt[k] = 0;
                end
                for (int i = 0; i < n; i++) begin
                    c = member_of[i];
                    sum_d[c] += longint'(warp_dil[i]);
                    sum_s[c] += longint'(warp_shf[i]);
                    cnt[c]++;
                end
                for (int i = 0; i < n; i++) begin
                    c = member_of[i];
                    r.out_index = i;
                    r.norm_dilation = warp_dil[i];
                    r.norm_shift = warp_shf[i];
                    r.out_cluster = c;
                    r.zero_mean = 1'b0;
                    r.last = (i == n - 1);
                    if (cfg_cluster_en[c] && cnt[c] > 0) begin
                        md = sum_d[c] / cnt[c];
                        ms = sum_s[c] / cnt[c];
                        if (md == 0) begin
                            r.zero_mean = 1'b1;
                        end else begin
                            r.norm_dilation = clamp_q((longint'(warp_dil[i]) * 65536) / md);
                            r.norm_shift = clamp_q(((longint'(warp_shf[i]) - ms) * 65536) / md);
                        end
                    end
                    pending_results.push_back(r);
                end
            end
        endcase
    endtask

    // drive one item, hold it until accepted
    task automatic send_item(t_in_item it, bit fixed, logic [31:0] fd, logic [31:0] fs, bit fz);
        int gap;
        t_out_item r;
        if ($urandom_range(0, 9) == 0) burst = ~burst;
        gap = burst ? 0 : $urandom_range(0, 14);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in <= it;
        i_in_valid <= 1'b1;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        if (it.req_type == REQ_FINISH) finishes_sent++;
        if (fixed) begin
            for (int i = 0; i < active_obs(); i++) begin
                r.out_index = i;
                r.norm_dilation = fd;
                r.norm_shift = fs;
                r.out_cluster = '0;
                r.zero_mean = fz;
                r.last = (i == active_obs() - 1);
                pending_results.push_back(r);
            end
        end else begin
            compose_or_finish(it);
        end
    endtask

    task automatic write_reg(logic sel, logic [31:0] value);
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {sel, 2'b00};
        pwdata <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (sel == REG_OBS_COUNT) cfg_obs_count = value[6:0];
        else cfg_cluster_en = value[15:0];
    endtask

    function automatic t_in_item mk(t_req rq, int idx, logic [31:0] d, logic [31:0] s, int c);
        t_in_item it;
        it.req_type = rq;
        it.obs_index = idx;
        it.step_dilation = d;
        it.step_shift = s;
        it.cluster_id = c;
        return it;
    endfunction

    function automatic void add_row(t_in_item it, int nc = -1, bit fx = 0,
                                    logic [31:0] fd = '0, logic [31:0] fs = '0, bit fz = 0);
        t_row row;
        row.item = it;
        row.new_count = nc;
        row.fixed = fx;
        row.fix_dil = fd;
        row.fix_shf = fs;
        row.fix_zero = fz;
        directed.push_back(row);
    endfunction

    function automatic t_in_item random_item();
        t_in_item it;
        int pick;
        int n;
        n = active_obs();
        pick = $urandom_range(0, 99);
        it.req_type = pick < 50 ? REQ_COMPOSE : pick < 75 ? REQ_MEMBER :
                      pick < 80 ? REQ_RESTART : pick < 88 ? REQ_FINISH : t_req'($urandom_range(0, 3));
        it.obs_index = ($urandom_range(0, 99) < 85) ? $urandom_range(0, n - 1) : $urandom_range(0, 63);
        pick = $urandom_range(0, 99);
        if (pick < 60) it.step_dilation = Q_ONE + $urandom_range(0, 32767) - 16384;
        else if (pick < 70) it.step_dilation = '0;
        else it.step_dilation = $urandom;
        if ($urandom_range(0, 99) < 70) it.step_shift = $urandom_range(0, 524287) - 262144;
        else it.step_shift = $urandom;
        it.cluster_id = ($urandom_range(0, 99) < 70) ? $urandom_range(0, 3) : $urandom_range(0, 15);
        return it;
    endfunction

    task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
        if (want !== got) begin
            errors++;
            $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
        end
    endtask

    // result side: compare, then draw the stall for the next item
    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            results_seen++;
            if (pending_results.size() == 0) begin
                errors++;
                $display("%0t: unexpected result, expected none, got %p", $time, o_out);
            end else begin
                want = pending_results.pop_front();
                check_field("out_index", want.out_index, o_out.out_index);
                check_field("norm_dilation", want.norm_dilation, o_out.norm_dilation);
                check_field("norm_shift", want.norm_shift, o_out.norm_shift);
                check_field("out_cluster", want.out_cluster, o_out.out_cluster);
                check_field("zero_mean", want.zero_mean, o_out.zero_mean);
                check_field("last", want.last, o_out.last);
            end
            stall_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 14);
        end
        if (stall_left > 0) begin
            i_out_stall <= 1'b1;
            stall_left--;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) || (psel && penable))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("affine_warp_compose_normalize_test NOT OK");
            $finish;
        end
    end

    initial begin
        logic [6:0] phase_count[8];
        logic [15:0] phase_en[8];
        phase_count = '{7'd3, 7'd1, 7'd0, 7'd8, 7'd100, 7'd5, 7'd16, 7'd2};
        phase_en = '{16'hFFFF, 16'h0000, 16'h0001, 16'h8000, 16'hFFFF, 16'h0000, 16'h0000, 16'h0000};
        phase_en[5] = $urandom;
        phase_en[6] = $urandom;
        phase_en[7] = $urandom;
        cfg_obs_count = 7'd64;
        cfg_cluster_en = 16'hFFFF;
        for (int i = 0; i < N_OBS; i++) begin
            warp_dil[i] = Q_ONE;
            warp_shf[i] = '0;
            member_of[i] = '0;
        end

        // after reset every warp is the identity: mean is one, result is one
        add_row(mk(REQ_FINISH, 0, 0, 0, 0), -1, 1, Q_ONE, 32'h0, 0);
        add_row(mk(REQ_RESTART, 0, 0, 0, 0), 4);
        for (int i = 0; i < 4; i++) add_row(mk(REQ_COMPOSE, i, 32'h0, 32'h0003_0000, 0));
        // zero mean dilation: values pass unchanged, flag set
        add_row(mk(REQ_FINISH, 0, 0, 0, 0), -1, 1, 32'h0, 32'h0003_0000, 1);
        add_row(mk(REQ_RESTART, 0, 0, 0, 0));
        add_row(mk(REQ_COMPOSE, 0, 32'h7FFF_FFFF, 32'h8000_0000, 0));
        add_row(mk(REQ_COMPOSE, 0, 32'h7FFF_FFFF, 32'h8000_0000, 0));
        add_row(mk(REQ_COMPOSE, 1, 32'h8000_0000, 32'h7FFF_FFFF, 0));
        add_row(mk(REQ_COMPOSE, 1, 32'h8000_0000, 32'h7FFF_FFFF, 0));
        add_row(mk(REQ_COMPOSE, 2, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0));
        add_row(mk(REQ_MEMBER, 2, 0, 0, 15));
        add_row(mk(REQ_MEMBER, 3, 0, 0, 5));
        // out of range index: ignored
        add_row(mk(REQ_MEMBER, 63, 0, 0, 9));
        add_row(mk(REQ_COMPOSE, 40, 32'h2, 32'h1, 0));
        add_row(mk(REQ_MEMBER, 1, 0, 0, 1));
        add_row(mk(REQ_FINISH, 0, 0, 0, 0));
        add_row(mk(REQ_MEMBER, 0, 0, 0, 15));
        add_row(mk(REQ_COMPOSE, 3, 32'h0000_8000, 32'h0000_FFFF, 0));
        add_row(mk(REQ_FINISH, 0, 0, 0, 0));
        add_row(mk(REQ_RESTART, 0, 0, 0, 0));
        add_row(mk(REQ_FINISH, 0, 0, 0, 0));

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed[k]) begin
            if (directed[k].new_count >= 0) write_reg(REG_OBS_COUNT, directed[k].new_count);
            send_item(directed[k].item, directed[k].fixed, directed[k].fix_dil,
                      directed[k].fix_shf, directed[k].fix_zero);
        end

        for (int p = 0; p < 8; p++) begin
            write_reg(REG_OBS_COUNT, {25'd0, phase_count[p]});
            write_reg(REG_CLUSTER_EN, {16'd0, phase_en[p]});
            for (int k = 0; k < ITEMS_PER_PHASE; k++) send_item(random_item(), 0, '0, '0, 0);
            send_item(mk(REQ_FINISH, 0, 0, 0, 0), 0, '0, '0, 0);
        end
        i_in_valid <= 1'b0;

        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        errors += pending_results.size();
        $display("Covered %0d finish runs with %0d results over 8 register settings,",
                 finishes_sent, results_seen);
        $display("including saturation, zero mean dilation, disabled clusters and bad indexes.");
        if (errors == 0) begin
            $display("affine_warp_compose_normalize_test OK");
        end else begin
            $display("affine_warp_compose_normalize_test NOT OK");
        end
        $finish;
    end
endmodule
`default_nettype wire
